// ===== sv/ssq_pkg.sv =====
// ----------------------------------------------------------------------------
// ssq_pkg
// Shared types, codes and constants of the sixteen-step gate sequencer track.
// ----------------------------------------------------------------------------
package ssq_pkg;

    localparam int NUM_STEPS   = 16;
    localparam int STEP_W      = $clog2(NUM_STEPS);
    localparam int IDX_W       = 4;
    localparam int ELAPSED_W   = 16;
    localparam int MAX_RESULTS = 5;
    localparam int CNT_W       = $clog2(MAX_RESULTS + 1);

    typedef enum logic [1:0] {
        CMD_CLOCK  = 2'd0,
        CMD_SET    = 2'd1,
        CMD_TOGGLE = 2'd2,
        CMD_TICK   = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        KIND_MIDI   = 2'd0,
        KIND_PIXEL  = 2'd1,
        KIND_STATUS = 2'd2
    } t_kind;

    typedef enum logic [2:0] {
        REG_MIDI_CHANNEL  = 3'd0,
        REG_MIDI_NOTE     = 3'd1,
        REG_NOTE_VELOCITY = 3'd2,
        REG_GATE_DURATION = 3'd3,
        REG_PIXEL_MAP     = 3'd4
    } t_cfg_reg;

    localparam logic [1:0] COL_ON_IDLE  = 2'd0;
    localparam logic [1:0] COL_ON_HEAD  = 2'd1;
    localparam logic [1:0] COL_OFF_IDLE = 2'd2;
    localparam logic [1:0] COL_OFF_HEAD = 2'd3;

    localparam logic [7:0] NOTE_ON_STATUS  = 8'h90;
    localparam logic [7:0] NOTE_OFF_STATUS = 8'h80;

    localparam logic [4:0]  RST_MIDI_CHANNEL  = 5'd1;
    localparam logic [6:0]  RST_MIDI_NOTE     = 7'd60;
    localparam logic [6:0]  RST_NOTE_VELOCITY = 7'd100;
    localparam logic [15:0] RST_GATE_DURATION = 16'd100;
    localparam logic [63:0] RST_PIXEL_MAP     = 64'hFEDC_BA98_7654_3210;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] midi_byte;
        logic [3:0] pixel_index;
        logic [1:0] pixel_color;
    } t_result;

    // Nibble number step of the map is the pixel that shows that step.
    function automatic logic [3:0] pixel_of(input logic [63:0] map, input logic [3:0] step);
        pixel_of = map[{step, 2'b00} +: 4];
    endfunction

endpackage

// ===== sv/step_sequencer_track_midi_gate_unit.sv =====
// ----------------------------------------------------------------------------
// step_sequencer_track_midi_gate_unit
// Sixteen-step gate sequencer track with MIDI byte and pixel update output.
// ----------------------------------------------------------------------------
// An accepted item waits in stage 1 until the result line is free; it then commits
// and loads its results: five for a clock item, one each for set, toggle and tick.
// The single result port sends one result per cycle while m_axis_tready is high.
// The pattern memory is read at transfer and written back when the item commits.
// Reset is synchronous, active low; pattern entries read as off until written,
// through per-step valid flags, so no clearing pass is needed.
module step_sequencer_track_midi_gate_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // step_index[3:0], step_value[4]
    input  logic [1:0]  s_axis_tuser,   // cmd[1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // midi_byte[7:0], pixel_index[11:8],
                                        // pixel_color[13:12], gate_level[14],
                                        // play_step[18:15]
    output logic [1:0]  m_axis_tuser,   // kind[1:0]
    output logic        m_axis_tlast,   // last_flag
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [63:0] i_cfg_data
);
    import ssq_pkg::*;

    // Configuration registers
    logic [4:0]  r_midi_channel;
    logic [6:0]  r_midi_note;
    logic [6:0]  r_note_velocity;
    logic [15:0] r_gate_duration;
    logic [63:0] r_pixel_map;

    // Track state
    logic [STEP_W-1:0]    r_playhead,     n_playhead;
    logic                 r_gate_on,      n_gate_on;
    logic [ELAPSED_W-1:0] r_gate_elapsed, n_gate_elapsed;
    logic [NUM_STEPS-1:0] r_valid;

    // Stage 1: item waiting for its pattern read data
    logic             r_s1_valid;
    t_cmd             r_s1_cmd;
    logic [IDX_W-1:0] r_s1_idx;
    logic             r_s1_val;
    logic             r_rd_vld_a, r_rd_vld_b;
    logic             r_rd_hit_a, r_rd_hit_b;
    logic             r_fwd_data;

    // Result shift line
    t_result          r_em_slot [MAX_RESULTS];
    t_result          n_em_slot [MAX_RESULTS];
    logic [CNT_W-1:0] r_em_left, n_em_left;

    logic              in_fire, s1_fire, out_fire, em_free;
    t_cmd              in_cmd;
    logic [STEP_W-1:0] addr_a, addr_b, nxt_step, eff_next;
    logic [0:0]        q_a, q_b;
    logic              pat_a, pat_b, idx_ok, we, wdata;
    logic [STEP_W-1:0] waddr;
    logic [3:0]        nib;
    logic [ELAPSED_W-1:0] elapsed_inc;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_midi_channel  <= RST_MIDI_CHANNEL;
            r_midi_note     <= RST_MIDI_NOTE;
            r_note_velocity <= RST_NOTE_VELOCITY;
            r_gate_duration <= RST_GATE_DURATION;
            r_pixel_map     <= RST_PIXEL_MAP;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (t_cfg_reg'(i_cfg_index))
                REG_MIDI_CHANNEL:  r_midi_channel  <= i_cfg_data[4:0];
                REG_MIDI_NOTE:     r_midi_note     <= i_cfg_data[6:0];
                REG_NOTE_VELOCITY: r_note_velocity <= i_cfg_data[6:0];
                REG_GATE_DURATION: r_gate_duration <= i_cfg_data[15:0];
                REG_PIXEL_MAP:     r_pixel_map     <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Handshake
    assign out_fire      = m_axis_tvalid && m_axis_tready;
    assign em_free       = (r_em_left == '0) || (out_fire && r_em_left == CNT_W'(1));
    assign s1_fire       = r_s1_valid && em_free;
    assign s_axis_tready = !r_s1_valid || s1_fire;
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign in_cmd        = t_cmd'(s_axis_tuser);

    // Stage 1 values with forwarding of a write-back in the read cycle
    assign pat_a    = r_rd_hit_a ? r_fwd_data : (r_rd_vld_a & q_a[0]);
    assign pat_b    = r_rd_hit_b ? r_fwd_data : (r_rd_vld_b & q_b[0]);
    assign idx_ok   = {1'b0, r_s1_idx} < (IDX_W + 1)'(NUM_STEPS);
    assign nxt_step = (r_playhead == STEP_W'(NUM_STEPS - 1)) ? '0 : r_playhead + 1'b1;
    assign nib      = r_midi_channel[3:0] - 4'd1;
    assign elapsed_inc = (r_gate_elapsed == '1) ? r_gate_elapsed : r_gate_elapsed + 1'b1;

    assign we    = s1_fire && idx_ok && (r_s1_cmd == CMD_SET || r_s1_cmd == CMD_TOGGLE);
    assign waddr = r_s1_idx[STEP_W-1:0];
    assign wdata = (r_s1_cmd == CMD_SET) ? r_s1_val : !pat_a;

    always_comb begin
        n_playhead     = r_playhead;
        n_gate_on      = r_gate_on;
        n_gate_elapsed = r_gate_elapsed;
        n_em_left      = r_em_left;
        for (int i = 0; i < MAX_RESULTS; i++) begin
            n_em_slot[i] = r_em_slot[i];
        end
        if (out_fire) begin
            n_em_left = r_em_left - 1'b1;
            for (int i = 0; i < MAX_RESULTS - 1; i++) begin
                n_em_slot[i] = r_em_slot[i + 1];
            end
        end
        if (s1_fire) begin
            n_em_left    = CNT_W'(1);
            n_em_slot[0] = '{kind: KIND_STATUS, midi_byte: '0, pixel_index: '0,
                             pixel_color: '0};
            case (r_s1_cmd)
                CMD_CLOCK: begin
                    n_playhead   = nxt_step;
                    n_em_left    = CNT_W'(MAX_RESULTS);
                    n_em_slot[0] = '{kind: KIND_PIXEL, midi_byte: '0,
                                     pixel_index: pixel_of(r_pixel_map, 4'(r_playhead)),
                                     pixel_color: pat_a ? COL_ON_IDLE : COL_OFF_IDLE};
                    n_em_slot[1] = '{kind: KIND_PIXEL, midi_byte: '0,
                                     pixel_index: pixel_of(r_pixel_map, 4'(nxt_step)),
                                     pixel_color: pat_b ? COL_ON_HEAD : COL_OFF_HEAD};
                    n_em_slot[2] = '{kind: KIND_MIDI,
                                     midi_byte: (pat_b ? NOTE_ON_STATUS : NOTE_OFF_STATUS)
                                                | {4'd0, nib},
                                     pixel_index: '0, pixel_color: '0};
                    n_em_slot[3] = '{kind: KIND_MIDI, midi_byte: {1'b0, r_midi_note},
                                     pixel_index: '0, pixel_color: '0};
                    n_em_slot[4] = '{kind: KIND_MIDI,
                                     midi_byte: pat_b ? {1'b0, r_note_velocity} : 8'd0,
                                     pixel_index: '0, pixel_color: '0};
                    n_gate_on = pat_b;
                    if (pat_b) begin
                        n_gate_elapsed = '0;
                    end
                end
                CMD_TOGGLE: begin
                    if (idx_ok) begin
                        n_em_slot[0] = '{kind: KIND_PIXEL, midi_byte: '0,
                                         pixel_index: pixel_of(r_pixel_map, r_s1_idx),
                                         pixel_color: wdata ? COL_ON_IDLE : COL_OFF_IDLE};
                    end
                end
                CMD_TICK: begin
                    n_gate_elapsed = elapsed_inc;
                    if (r_gate_on && elapsed_inc > r_gate_duration) begin
                        n_gate_on = 1'b0;
                    end
                end
                default: ;
            endcase
        end
    end

    // A new item reads with the playhead that the committing item leaves behind.
    assign eff_next = (n_playhead == STEP_W'(NUM_STEPS - 1)) ? '0 : n_playhead + 1'b1;
    assign addr_a   = (in_cmd == CMD_CLOCK) ? n_playhead : s_axis_tdata[STEP_W-1:0];
    assign addr_b   = (in_cmd == CMD_CLOCK) ? eff_next : s_axis_tdata[STEP_W-1:0];

    // Two copies of the pattern give the two reads that a clock item needs.
    ssq_ram #(.WIDTH(1), .DEPTH(NUM_STEPS)) u_ram_a (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_re    (in_fire),
        .i_raddr (addr_a),
        .o_rdata (q_a)
    );

    ssq_ram #(.WIDTH(1), .DEPTH(NUM_STEPS)) u_ram_b (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_re    (in_fire),
        .i_raddr (addr_b),
        .o_rdata (q_b)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_playhead     <= '0;
            r_gate_on      <= 1'b0;
            r_gate_elapsed <= '0;
            r_valid        <= '0;
            r_s1_valid     <= 1'b0;
            r_em_left      <= '0;
        end else begin
            r_playhead     <= n_playhead;
            r_gate_on      <= n_gate_on;
            r_gate_elapsed <= n_gate_elapsed;
            r_em_left      <= n_em_left;
            if (we) begin
                r_valid[waddr] <= 1'b1;
            end
            if (in_fire) begin
                r_s1_valid <= 1'b1;
            end else if (s1_fire) begin
                r_s1_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < MAX_RESULTS; i++) begin
            r_em_slot[i] <= n_em_slot[i];
        end
        if (in_fire) begin
            r_s1_cmd   <= in_cmd;
            r_s1_idx   <= s_axis_tdata[IDX_W-1:0];
            r_s1_val   <= s_axis_tdata[IDX_W];
            r_rd_vld_a <= r_valid[addr_a];
            r_rd_vld_b <= r_valid[addr_b];
            r_rd_hit_a <= we && (waddr == addr_a);
            r_rd_hit_b <= we && (waddr == addr_b);
            r_fwd_data <= wdata;
        end
    end

    // Gate and playhead only change when the next item commits, after the
    // last result of this one has been transferred.
    assign m_axis_tvalid = (r_em_left != '0);
    assign m_axis_tlast  = (r_em_left == CNT_W'(1));
    assign m_axis_tuser  = r_em_slot[0].kind;
    assign m_axis_tdata  = {5'd0, 4'(r_playhead), r_gate_on, r_em_slot[0].pixel_color,
                            r_em_slot[0].pixel_index, r_em_slot[0].midi_byte};

`ifndef NO_ASSERTIONS
    a_clock_loads_five: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_fire && r_s1_cmd == CMD_CLOCK) |=> (r_em_left == CNT_W'(MAX_RESULTS)))
        else $error("clock item did not load five results");

    a_other_loads_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_fire && r_s1_cmd != CMD_CLOCK) |=> (r_em_left == CNT_W'(1)))
        else $error("non-clock item did not load one result");

    a_stage_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !s1_fire) |=> (r_s1_valid && $stable(r_s1_cmd) && $stable(r_s1_idx)))
        else $error("waiting item lost or changed");

    a_playhead_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ({1'b0, r_playhead} < (STEP_W + 1)'(NUM_STEPS)))
        else $error("playhead out of range");

    a_state_frozen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!s1_fire) |=> ($stable(r_playhead) && $stable(r_gate_on)))
        else $error("track state changed without a commit");
`endif

endmodule

// ===== sv/ssq_ram.sv =====
// ----------------------------------------------------------------------------
// ssq_ram
// Generic single-port-write, single-port-read RAM with a registered read.
// ----------------------------------------------------------------------------
module ssq_ram #(
    parameter int  WIDTH  = 1,
    parameter int  DEPTH  = 16,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= mem[i_raddr];
        end
    end

endmodule

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Checks the sixteen-step gate sequencer track against a predictor of its own.
// A driver sends clock, set, toggle and tick transfers in bursts, a monitor
// compares every result transfer with the oldest predicted one, and the
// configuration is changed between drained phases, extremes included.
// ----------------------------------------------------------------------------
module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    import ssq_pkg::*;

    localparam int SETTLE_CYCLES = 8;
    localparam int LONG_HOLD     = 400;
    localparam int QUIET_LIMIT   = 4000;
    localparam int RANDOM_PHASES = 7;
    localparam int PHASE_ITEMS   = 66;
    localparam int LONG_GATE_TICKS = 12;
    localparam int PRINT_LIMIT   = 50;

    typedef struct {
        t_cmd       cmd;
        logic [3:0] step_idx;
        logic       step_val;
    } t_track_item;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] midi_byte;
        logic [3:0] pixel_index;
        logic [1:0] pixel_color;
        logic       gate_level;
        logic [3:0] play_step;
        logic       last_flag;
    } t_track_result;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = '0;
    logic [1:0]  s_axis_tuser = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;
    logic        m_axis_tlast;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index = '0;
    logic [63:0] i_cfg_data = '0;

    step_sequencer_track_midi_gate_unit uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // Predicted track state and its copy of the registers.
    logic [NUM_STEPS-1:0] steps_on = '0;
    logic [3:0]  play_head = '0;
    logic        gate_high = 1'b0;
    logic [15:0] gate_elapsed = '0;
    logic [4:0]  cfg_channel = RST_MIDI_CHANNEL;
    logic [6:0]  cfg_note = RST_MIDI_NOTE;
    logic [6:0]  cfg_velocity = RST_NOTE_VELOCITY;
    logic [15:0] cfg_duration = RST_GATE_DURATION;
    logic [63:0] cfg_pixel_map = RST_PIXEL_MAP;

    t_track_item   pending_steps [$];
    t_track_result expected_results [$];
    int unsigned   mismatch_count = 0;
    int unsigned   result_count = 0;
    bit            sender_steady = 1'b0;
    int unsigned   hold_requests = 0;

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= PRINT_LIMIT) begin
            $display("MISMATCH: %s", msg);
        end
    endtask

    function automatic t_track_item step_item(input t_cmd cmd, input logic [3:0] idx,
                                              input logic val);
        t_track_item it;
        it.cmd = cmd;
        it.step_idx = idx;
        it.step_val = val;
        return it;
    endfunction

    function automatic t_track_item random_step_item();
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 40) begin
            return step_item(CMD_CLOCK, 4'($urandom), 1'($urandom));
        end else if (pick < 60) begin
            return step_item(CMD_SET, 4'($urandom), 1'($urandom));
        end else if (pick < 76) begin
            return step_item(CMD_TOGGLE, 4'($urandom), 1'($urandom));
        end
        return step_item(CMD_TICK, 4'($urandom), 1'($urandom));
    endfunction

    function automatic logic [3:0] pixel_for(input logic [3:0] step);
        return 4'(cfg_pixel_map >> {step, 2'b00});
    endfunction

    function automatic t_track_result make_result(input t_kind kind, input logic [7:0] mb,
                                                  input logic [3:0] pix,
                                                  input logic [1:0] col);
        t_track_result r;
        r = '0;
        r.kind = kind;
        r.midi_byte = mb;
        r.pixel_index = pix;
        r.pixel_color = col;
        return r;
    endfunction

    // Advances the predicted track by one accepted item and queues its results.
    task automatic predict_track(input t_track_item it);
        t_track_result outs [$];
        logic [3:0]    old_step;
        logic [7:0]    channel_bits;
        channel_bits = {4'h0, 4'(cfg_channel - 5'd1)};
        case (it.cmd)
            CMD_CLOCK: begin
                old_step = play_head;
                outs.push_back(make_result(KIND_PIXEL, 8'h00, pixel_for(old_step),
                    steps_on[old_step] ? COL_ON_IDLE : COL_OFF_IDLE));
                play_head = 4'((int'(play_head) + 1) % NUM_STEPS);
                outs.push_back(make_result(KIND_PIXEL, 8'h00, pixel_for(play_head),
                    steps_on[play_head] ? COL_ON_HEAD : COL_OFF_HEAD));
                if (steps_on[play_head]) begin
                    outs.push_back(make_result(KIND_MIDI, NOTE_ON_STATUS | channel_bits,
                                               4'h0, 2'd0));
                    outs.push_back(make_result(KIND_MIDI, {1'b0, cfg_note}, 4'h0, 2'd0));
                    outs.push_back(make_result(KIND_MIDI, {1'b0, cfg_velocity}, 4'h0, 2'd0));
                    gate_high = 1'b1;
                    gate_elapsed = '0;
                end else begin
                    // Note-off always carries velocity zero; the timer keeps running.
                    outs.push_back(make_result(KIND_MIDI, NOTE_OFF_STATUS | channel_bits,
                                               4'h0, 2'd0));
                    outs.push_back(make_result(KIND_MIDI, {1'b0, cfg_note}, 4'h0, 2'd0));
                    outs.push_back(make_result(KIND_MIDI, 8'h00, 4'h0, 2'd0));
                    gate_high = 1'b0;
                end
            end
            CMD_SET: begin
                if (int'(it.step_idx) < NUM_STEPS) begin
                    steps_on[it.step_idx] = it.step_val;
                end
                outs.push_back(make_result(KIND_STATUS, 8'h00, 4'h0, 2'd0));
            end
            CMD_TOGGLE: begin
                if (int'(it.step_idx) < NUM_STEPS) begin
                    steps_on[it.step_idx] = ~steps_on[it.step_idx];
                    outs.push_back(make_result(KIND_PIXEL, 8'h00, pixel_for(it.step_idx),
                        steps_on[it.step_idx] ? COL_ON_IDLE : COL_OFF_IDLE));
                end else begin
                    outs.push_back(make_result(KIND_STATUS, 8'h00, 4'h0, 2'd0));
                end
            end
            default: begin
                if (gate_elapsed != 16'hFFFF) begin
                    gate_elapsed = gate_elapsed + 16'd1;
                end
                if (gate_high && gate_elapsed > cfg_duration) begin
                    gate_high = 1'b0;
                end
                outs.push_back(make_result(KIND_STATUS, 8'h00, 4'h0, 2'd0));
            end
        endcase
        foreach (outs[k]) begin
            outs[k].gate_level = gate_high;
            outs[k].play_step = play_head;
            outs[k].last_flag = (k == outs.size() - 1);
            expected_results.push_back(outs[k]);
        end
    endtask

    task automatic apply_register(input logic [2:0] index, input logic [63:0] data);
        case (index)
            REG_MIDI_CHANNEL:  cfg_channel = data[4:0];
            REG_MIDI_NOTE:     cfg_note = data[6:0];
            REG_NOTE_VELOCITY: cfg_velocity = data[6:0];
            REG_GATE_DURATION: cfg_duration = data[15:0];
            REG_PIXEL_MAP:     cfg_pixel_map = data;
            default: ;
        endcase
    endtask

    // Called at a rising edge; leaves valid high so back-to-back writes need no gap.
    task automatic write_register(input logic [2:0] index, input logic [63:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        apply_register(index, data);
    endtask

    task automatic program_phase(input int phase_no);
        logic [63:0] noise;
        logic [4:0]  channel;
        logic [6:0]  note;
        logic [6:0]  velocity;
        logic [15:0] duration;
        logic [63:0] map;
        noise = {$urandom, $urandom};
        case (phase_no)
            0: begin
                channel = 5'd16;
                note = 7'd127;
                velocity = 7'd127;
                duration = 16'd0;
                map = '1;
            end
            1: begin
                channel = 5'd0;
                note = 7'd0;
                velocity = 7'd0;
                duration = 16'd3;
                map = '0;
            end
            2: begin
                channel = 5'd31;
                note = 7'($urandom);
                velocity = 7'($urandom);
                duration = 16'd1;
                map = {$urandom, $urandom};
            end
            default: begin
                channel = ($urandom_range(0, 3) == 0) ? 5'($urandom)
                                                     : 5'($urandom_range(1, 16));
                note = 7'($urandom);
                velocity = 7'($urandom);
                duration = ($urandom_range(0, 4) == 0) ? 16'($urandom)
                                                      : 16'($urandom_range(0, 12));
                map = {$urandom, $urandom};
            end
        endcase
        // Bits above each register's width carry noise that the block must drop.
        write_register(REG_MIDI_CHANNEL, {noise[63:5], channel});
        write_register(REG_MIDI_NOTE, {noise[63:7], note});
        write_register(REG_NOTE_VELOCITY, {noise[63:7], velocity});
        write_register(REG_GATE_DURATION, {noise[63:16], duration});
        write_register(REG_PIXEL_MAP, map);
        if (phase_no == 0) begin
            for (int spare = int'(REG_PIXEL_MAP) + 1; spare < 2 ** $bits(i_cfg_index);
                 spare++) begin
                write_register(3'(spare), {$urandom, $urandom});
            end
        end
        i_cfg_valid <= 1'b0;
    endtask

    // Returns at a rising edge once every item is sent and every result is back.
    task automatic wait_drained();
        do begin
            @(posedge i_clk);
            #1;
        end while (pending_steps.size() != 0 || s_axis_tvalid || expected_results.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Sender: bursts of random length separated by random gaps.
    always @(posedge i_clk) begin : drive_steps
        t_track_item offered;
        int          burst_left;
        int          gap_left;
        logic        offer;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            burst_left = 0;
            gap_left = 0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                predict_track(offered);
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                offer = 1'b0;
                if (gap_left > 0 && !sender_steady) begin
                    gap_left--;
                end else if (pending_steps.size() > 0) begin
                    offered = pending_steps.pop_front();
                    offer = 1'b1;
                    if (burst_left > 0) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(1, 24);
                        gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
                    end
                end
                s_axis_tvalid <= offer;
                if (offer) begin
                    s_axis_tdata <= {3'b000, offered.step_val, offered.step_idx};
                    s_axis_tuser <= offered.cmd;
                end
            end
        end
    end

    // Receiver: stalls on a rotating pattern, with the occasional long hold.
    always @(posedge i_clk) begin : drive_ready
        logic [15:0] stall_pattern;
        int          pattern_left;
        int          hold_left;
        int unsigned hold_seen;
        int unsigned pick;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            pattern_left = 0;
            hold_left = 0;
            hold_seen = 0;
        end else if (hold_seen != hold_requests) begin
            hold_seen = hold_requests;
            hold_left = LONG_HOLD;
            m_axis_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end else begin
            if (pattern_left == 0) begin
                pick = $urandom_range(0, 3);
                if (pick == 0) begin
                    stall_pattern = 16'hFFFF;
                end else if (pick == 1) begin
                    stall_pattern = 16'($urandom & $urandom) | 16'h0001;
                end else begin
                    stall_pattern = 16'($urandom) | 16'h0001;
                end
                pattern_left = $urandom_range(20, 200);
            end
            pattern_left--;
            stall_pattern = {stall_pattern[14:0], stall_pattern[15]};
            m_axis_tready <= stall_pattern[0];
        end
    end

    task automatic compare_field(input string name, input logic [7:0] got,
                                 input logic [7:0] want);
        if (got !== want) begin
            report_mismatch($sformatf("result %0d %s: got %0h, expected %0h",
                                      result_count, name, got, want));
        end
    endtask

    always @(posedge i_clk) begin : check_results
        t_track_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_results.size() == 0) begin
                report_mismatch($sformatf("result %0d arrived with none expected: %h/%h/%b",
                                          result_count, m_axis_tuser, m_axis_tdata,
                                          m_axis_tlast));
            end else begin
                want = expected_results.pop_front();
                compare_field("kind", {6'b0, m_axis_tuser}, {6'b0, want.kind});
                compare_field("midi_byte", m_axis_tdata[7:0], want.midi_byte);
                compare_field("pixel_index", {4'b0, m_axis_tdata[11:8]},
                              {4'b0, want.pixel_index});
                compare_field("pixel_color", {6'b0, m_axis_tdata[13:12]},
                              {6'b0, want.pixel_color});
                compare_field("gate_level", {7'b0, m_axis_tdata[14]}, {7'b0, want.gate_level});
                compare_field("play_step", {4'b0, m_axis_tdata[18:15]}, {4'b0, want.play_step});
                compare_field("last_flag", {7'b0, m_axis_tlast}, {7'b0, want.last_flag});
            end
            result_count++;
        end
    end

    // Ends the run when no transfer of any kind happens for too long.
    always @(posedge i_clk) begin : watchdog
        int quiet_cycles;
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
                || (i_cfg_valid && o_cfg_ready) || !i_rst_n) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("testbench: done, errors");
            $finish;
        end
    end

    initial begin : run_phases
        logic [3:0] target;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed items under the reset configuration.
        @(negedge i_clk);
        pending_steps.push_back(step_item(CMD_CLOCK, 4'h0, 1'b0));
        pending_steps.push_back(step_item(CMD_SET, 4'd2, 1'b1));
        pending_steps.push_back(step_item(CMD_SET, 4'd15, 1'b1));
        pending_steps.push_back(step_item(CMD_CLOCK, 4'hF, 1'b1));
        pending_steps.push_back(step_item(CMD_TICK, 4'h0, 1'b0));
        pending_steps.push_back(step_item(CMD_TICK, 4'hF, 1'b1));
        pending_steps.push_back(step_item(CMD_TOGGLE, 4'd0, 1'b0));
        pending_steps.push_back(step_item(CMD_TOGGLE, 4'd15, 1'b1));
        pending_steps.push_back(step_item(CMD_TOGGLE, 4'd15, 1'b0));
        pending_steps.push_back(step_item(CMD_SET, 4'd3, 1'b0));
        pending_steps.push_back(step_item(CMD_CLOCK, 4'h5, 1'b0));
        pending_steps.push_back(step_item(CMD_SET, 4'd4, 1'b1));
        pending_steps.push_back(step_item(CMD_SET, 4'd10, 1'b1));
        pending_steps.push_back(step_item(CMD_SET, 4'd10, 1'b0));
        pending_steps.push_back(step_item(CMD_CLOCK, 4'hA, 1'b1));
        pending_steps.push_back(step_item(CMD_TICK, 4'h3, 1'b1));
        pending_steps.push_back(step_item(CMD_CLOCK, 4'h0, 1'b0));
        pending_steps.push_back(step_item(CMD_TOGGLE, 4'd6, 1'b1));
        pending_steps.push_back(step_item(CMD_CLOCK, 4'h6, 1'b0));
        pending_steps.push_back(step_item(CMD_CLOCK, 4'h9, 1'b1));
        wait_drained();

        for (int phase_no = 0; phase_no < RANDOM_PHASES; phase_no++) begin
            program_phase(phase_no);
            @(negedge i_clk);
            // One phase runs with the receiver held off and the sender never pausing,
            // so the block fills up and stalls its input.
            sender_steady = (phase_no == 2);
            if (phase_no == 2) begin
                hold_requests++;
            end
            repeat (PHASE_ITEMS) pending_steps.push_back(random_step_item());
            wait_drained();
        end

        // Longest gate: the elapsed count can never exceed the duration.
        write_register(REG_GATE_DURATION, 64'h0000_0000_0000_FFFF);
        i_cfg_valid <= 1'b0;
        @(negedge i_clk);
        sender_steady = 1'b1;
        target = 4'((int'(play_head) + 1) % NUM_STEPS);
        pending_steps.push_back(step_item(CMD_SET, target, 1'b1));
        pending_steps.push_back(step_item(CMD_CLOCK, 4'($urandom), 1'($urandom)));
        repeat (LONG_GATE_TICKS) begin
            pending_steps.push_back(step_item(CMD_TICK, 4'($urandom), 1'($urandom)));
        end
        wait_drained();

        // With the duration equal to the count so far, one more tick drops the gate.
        write_register(REG_GATE_DURATION, 64'(LONG_GATE_TICKS));
        i_cfg_valid <= 1'b0;
        @(negedge i_clk);
        target = 4'((int'(play_head) + 1) % NUM_STEPS);
        pending_steps.push_back(step_item(CMD_SET, target, 1'b0));
        pending_steps.push_back(step_item(CMD_TICK, 4'h0, 1'b0));
        pending_steps.push_back(step_item(CMD_CLOCK, 4'h0, 1'b0));
        wait_drained();
        sender_steady = 1'b0;

        foreach (expected_results[k]) begin
            report_mismatch($sformatf("expected result never arrived: %h",
                                      expected_results[k]));
        end
        if (mismatch_count == 0) begin
            $display("testbench: done, clean");
        end else begin
            $display("testbench: done, errors");
        end
        $finish;
    end

endmodule
